FILE: src/accel_double_tap_detector_unit_defines.svh
// Assertion helpers shared by the checker.
`ifndef ACCEL_DOUBLE_TAP_DETECTOR_UNIT_DEFINES_SVH
`define ACCEL_DOUBLE_TAP_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ADTD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ADTD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/adtd_pkg.sv
`default_nettype none

package adtd_pkg;

    localparam logic [15:0] ADTD_JERK_THR_RST = 16'd3441;
    localparam logic [15:0] ADTD_MIN_GAP_RST  = 16'd70;
    localparam logic [15:0] ADTD_MAX_GAP_RST  = 16'd480;
    localparam logic [15:0] ADTD_LOCKOUT_RST  = 16'd550;
    localparam logic [15:0] ADTD_ONE_G        = 16'd8192;
    localparam logic [15:0] ADTD_MAG_MAX      = 16'd56755;

    typedef enum logic [1:0] {
        CFG_JERK_THR = 2'd0,
        CFG_MIN_GAP  = 2'd1,
        CFG_MAX_GAP  = 2'd2,
        CFG_LOCKOUT  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic [15:0] jerk_thr;
        logic [15:0] min_gap;
        logic [15:0] max_gap;
        logic [15:0] lockout;
    } t_tap_cfg;

endpackage

`default_nettype wire

FILE: src/adtd_isqrt.sv
`default_nettype none

module adtd_isqrt import adtd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_radicand,
    output logic             o_done,
    output logic [15:0]      o_root
);

    logic [31:0] r_rad;
    logic [16:0] r_rem;
    logic [15:0] r_root;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [18:0] w_cur;
    logic [18:0] w_trial;
    logic        w_ge;
    logic [18:0] w_diff;

    // one result bit per step, two radicand bits consumed
    assign w_cur   = {r_rem, r_rad[31:30]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = (w_cur >= w_trial);
    assign w_diff  = w_cur - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[29:0], 2'b00};
            r_rem  <= w_ge ? w_diff[16:0] : w_cur[16:0];
            r_root <= {r_root[14:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

FILE: src/adtd_tap.sv
`default_nettype none

module adtd_tap import adtd_pkg::*; #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic [15:0]           i_mag,
    input  wire logic [TIME_WIDTH-1:0] i_now,
    input  wire t_tap_cfg              i_cfg,
    output logic                       o_fired
);

    logic [15:0]           r_prev;
    logic                  r_pending;
    logic [TIME_WIDTH-1:0] r_first;
    logic [TIME_WIDTH-1:0] r_lock_end;

    logic                  n_pending;
    logic [TIME_WIDTH-1:0] n_first;
    logic [TIME_WIDTH-1:0] n_lock_end;

    logic [15:0]           w_jerk;
    logic [TIME_WIDTH-1:0] w_dt;
    logic                  w_tap;
    logic                  w_open;
    logic                  w_in_win;
    logic                  w_late;

    always_comb begin
        w_jerk   = (i_mag >= r_prev) ? (i_mag - r_prev) : (r_prev - i_mag);
        w_dt     = i_now - r_first;
        w_tap    = (w_jerk >= i_cfg.jerk_thr);
        w_open   = (i_now > r_lock_end);
        w_late   = (w_dt > TIME_WIDTH'(i_cfg.max_gap));
        w_in_win = (w_dt >= TIME_WIDTH'(i_cfg.min_gap)) && !w_late;

        n_pending  = r_pending;
        n_first    = r_first;
        n_lock_end = r_lock_end;
        o_fired    = 1'b0;
        if (w_open) begin
            if (w_tap) begin
                if (!r_pending) begin
                    n_pending = 1'b1;
                    n_first   = i_now;
                end else if (w_in_win) begin
                    o_fired    = 1'b1;
                    n_pending  = 1'b0;
                    n_lock_end = i_now + TIME_WIDTH'(i_cfg.lockout);
                end else if (w_late) begin
                    n_first = i_now;
                end
            end else if (r_pending && w_late) begin
                n_pending = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= ADTD_ONE_G;
            r_pending  <= 1'b0;
            r_first    <= '0;
            r_lock_end <= '0;
        end else if (i_en) begin
            r_prev     <= i_mag;
            r_pending  <= n_pending;
            r_first    <= n_first;
            r_lock_end <= n_lock_end;
        end
    end

endmodule

`default_nettype wire

FILE: src/accel_double_tap_detector_unit.sv
// A sample is squared, summed and square-rooted, then its result is registered.
// A new sample is taken only after the last one has made the three passes
//   through the shared squaring multiplier and the 16-step square-root unit.
// A finished result waits in the output register while the next sample is taken.
// Reset: synchronous, active low; clears the sequencer, loads the register
//   defaults and sets the previous magnitude to one g with no tap pending.
`default_nettype none

module accel_double_tap_detector_unit import adtd_pkg::*; #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32], timestamp_ms [79:48]
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // magnitude [15:0]
    output logic [15:0]      m_axis_tdata,
    // double_tap [0]
    output logic             m_axis_tuser,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_data
);

    t_state r_state, n_state;

    t_tap_cfg r_cfg;

    logic signed [15:0]    r_x, r_y, r_z;
    logic [TIME_WIDTH-1:0] r_now;
    logic [TIME_WIDTH-1:0] w_now;
    logic [1:0]            r_cnt;
    logic [30:0]           r_prod;
    logic [31:0]           r_acc;

    logic signed [15:0] w_axis;
    logic signed [31:0] w_sq;
    logic [31:0]        w_acc_sum;

    logic        w_in_req;
    logic        w_sqrt_start;
    logic        w_sqrt_done;
    logic [15:0] w_root;
    logic        w_load_out;
    logic        w_fired;

    logic        r_m_valid;
    logic [15:0] r_m_mag;
    logic        r_m_tap;

    generate
        if (TIME_WIDTH <= 32) begin : g_now_cut
            assign w_now = s_axis_tdata[48 +: TIME_WIDTH];
        end else begin : g_now_ext
            assign w_now = TIME_WIDTH'(s_axis_tdata[79:48]);
        end
    endgenerate

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.jerk_thr <= ADTD_JERK_THR_RST;
            r_cfg.min_gap  <= ADTD_MIN_GAP_RST;
            r_cfg.max_gap  <= ADTD_MAX_GAP_RST;
            r_cfg.lockout  <= ADTD_LOCKOUT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_JERK_THR: r_cfg.jerk_thr <= i_cfg_data;
                CFG_MIN_GAP:  r_cfg.min_gap  <= i_cfg_data;
                CFG_MAX_GAP:  r_cfg.max_gap  <= i_cfg_data;
                CFG_LOCKOUT:  r_cfg.lockout  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_in_req = s_axis_tvalid && s_axis_tready;

    always_comb begin
        case (r_cnt)
            2'd0:    w_axis = r_x;
            2'd1:    w_axis = r_y;
            default: w_axis = r_z;
        endcase
    end

    assign w_sq      = w_axis * w_axis;
    assign w_acc_sum = r_acc + 32'(r_prod);

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_sqrt_start  = 1'b0;
        w_load_out    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (r_cnt == 2'd3) begin
                    w_sqrt_start = 1'b1;
                    n_state      = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (w_sqrt_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!r_m_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_req) begin
            r_cnt <= '0;
        end else if (r_state == ST_SQUARE) begin
            r_cnt <= r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_req) begin
            r_x   <= s_axis_tdata[15:0];
            r_y   <= s_axis_tdata[31:16];
            r_z   <= s_axis_tdata[47:32];
            r_now <= w_now;
            r_acc <= '0;
        end else if (r_state == ST_SQUARE) begin
            r_prod <= w_sq[30:0];
            if (r_cnt != 2'd0) begin
                r_acc <= w_acc_sum;
            end
        end
    end

    adtd_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_acc_sum),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    adtd_tap #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_tap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_load_out),
        .i_mag   (w_root),
        .i_now   (r_now),
        .i_cfg   (r_cfg),
        .o_fired (w_fired)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_m_mag <= w_root;
            r_m_tap <= w_fired;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_mag;
    assign m_axis_tuser  = r_m_tap;

endmodule

`default_nettype wire

FILE: src/adtd_checker.sv
`default_nettype none

`include "accel_double_tap_detector_unit_defines.svh"

module adtd_checker import adtd_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    `ADTD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    `ADTD_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after a request")

    `ADTD_ASSERT_NEXT(a_no_early_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result one cycle after request")

    `ADTD_ASSERT_NOW(a_mag_range, m_axis_tvalid, m_axis_tdata <= ADTD_MAG_MAX, "magnitude out of range")

endmodule

bind accel_double_tap_detector_unit adtd_checker u_adtd_checker (.*);

`default_nettype wire
